@@ hw/rtl/mia_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mia_pkg
// Types, operation codes and helpers shared by the multiwidth integer ALU.
// ----------------------------------------------------------------------------
package mia_pkg;

   localparam int DATA_W        = 64;
   localparam int MAX_WIDTH_DEF = 64;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [4:0] FN_ADD  = 5'd0;
   localparam logic [4:0] FN_SUB  = 5'd1;
   localparam logic [4:0] FN_MUL  = 5'd2;
   localparam logic [4:0] FN_UDIV = 5'd3;
   localparam logic [4:0] FN_SDIV = 5'd4;
   localparam logic [4:0] FN_AND  = 5'd5;
   localparam logic [4:0] FN_OR   = 5'd6;
   localparam logic [4:0] FN_XOR  = 5'd7;
   localparam logic [4:0] FN_SHL  = 5'd8;
   localparam logic [4:0] FN_SHR  = 5'd9;
   localparam logic [4:0] FN_SAR  = 5'd10;
   localparam logic [4:0] FN_SEXT = 5'd11;
   localparam logic [4:0] FN_EQ   = 5'd12;
   localparam logic [4:0] FN_NE   = 5'd13;
   localparam logic [4:0] FN_UGT  = 5'd14;
   localparam logic [4:0] FN_UGE  = 5'd15;
   localparam logic [4:0] FN_ULT  = 5'd16;
   localparam logic [4:0] FN_ULE  = 5'd17;
   localparam logic [4:0] FN_SGT  = 5'd18;
   localparam logic [4:0] FN_SGE  = 5'd19;
   localparam logic [4:0] FN_SLT  = 5'd20;
   localparam logic [4:0] FN_SLE  = 5'd21;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIV0  = 2'd1;
   localparam logic [1:0] ST_UNSUP = 2'd2;

   typedef struct packed {
      logic [4:0]        func;
      logic [1:0]        width_code;
      logic [DATA_W-1:0] left_operand;
      logic [DATA_W-1:0] right_operand;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] result_value;
      logic [1:0]        status;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_SIMPLE,
      KIND_SEXT,
      KIND_MUL,
      KIND_DIV
   } kind_type;

   // acc: result, dividend/quotient or multiplicand; dvs: divisor or multiplier
   typedef struct packed {
      kind_type          kind;
      logic              neg;
      logic [1:0]        wcode;
      logic [1:0]        status;
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] dvs;
   } entry_type;

   function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] wc);
      logic [DATA_W-1:0] m;
      begin
         case (wc)
            2'd0:    m = DATA_W'(64'h0000_0000_0000_00ff);
            2'd1:    m = DATA_W'(64'h0000_0000_0000_ffff);
            2'd2:    m = DATA_W'(64'h0000_0000_ffff_ffff);
            default: m = '1;
         endcase
         return m;
      end
   endfunction

endpackage

@@ hw/rtl/mia_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mia_front
// Decodes a beat, cuts operands to width, finishes add, subtract, logic, shift
// and compare operations and prepares multiply and divide work for the back end.
// ----------------------------------------------------------------------------
module mia_front #(
   parameter int MAX_WIDTH = mia_pkg::MAX_WIDTH_DEF
) (
   input  mia_pkg::req_type   req_payload,
   output mia_pkg::entry_type entry
);
   import mia_pkg::*;

   localparam int SHW = $clog2(MAX_WIDTH);

   logic [6:0]           w_bits;
   logic                 w_ok;
   logic [DATA_W-1:0]    mask_full;
   logic [MAX_WIDTH-1:0] mask, sbit, a, b, ase, ua, ub, res;
   logic                 an, bn, big;

   always_comb begin
      w_bits    = 7'd8 << req_payload.width_code;
      w_ok      = (32'(w_bits) <= 32'(MAX_WIDTH));
      mask_full = width_mask(req_payload.width_code);
      mask      = mask_full[MAX_WIDTH-1:0];
      sbit      = mask ^ (mask >> 1);
      a         = req_payload.left_operand[MAX_WIDTH-1:0] & mask;
      b         = req_payload.right_operand[MAX_WIDTH-1:0] & mask;
      an        = |(a & sbit);
      bn        = |(b & sbit);
      ase       = a | (an ? ~mask : '0);
      ua        = an ? ((-a) & mask) : a;
      ub        = bn ? ((-b) & mask) : b;
      big       = (b >= MAX_WIDTH'(w_bits));
      res       = '0;

      entry        = '0;
      entry.kind   = KIND_SIMPLE;
      entry.wcode  = req_payload.width_code;
      entry.status = ST_OK;

      case (req_payload.func)
         FN_ADD:  res = a + b;
         FN_SUB:  res = a - b;
         FN_MUL: begin
            entry.kind = KIND_MUL;
            res        = a;
            entry.dvs[MAX_WIDTH-1:0] = b;
         end
         FN_UDIV: begin
            if (b == '0) begin
               entry.status = ST_DIV0;
            end else begin
               entry.kind = KIND_DIV;
               res        = a;
               entry.dvs[MAX_WIDTH-1:0] = b;
            end
         end
         FN_SDIV: begin
            if (b == '0) begin
               entry.status = ST_DIV0;
            end else begin
               entry.kind = KIND_DIV;
               entry.neg  = an ^ bn;
               res        = ua;
               entry.dvs[MAX_WIDTH-1:0] = ub;
            end
         end
         FN_AND:  res = a & b;
         FN_OR:   res = a | b;
         FN_XOR:  res = a ^ b;
         FN_SHL:  res = big ? '0 : (a << b[SHW-1:0]);
         FN_SHR:  res = big ? '0 : (a >> b[SHW-1:0]);
         FN_SAR:  res = big ? (an ? mask : '0)
                            : MAX_WIDTH'($signed(ase) >>> b[SHW-1:0]);
         FN_SEXT: begin
            entry.kind = KIND_SEXT;
            res        = ase;
         end
         FN_EQ:   res = MAX_WIDTH'(a == b);
         FN_NE:   res = MAX_WIDTH'(a != b);
         FN_UGT:  res = MAX_WIDTH'(a > b);
         FN_UGE:  res = MAX_WIDTH'(a >= b);
         FN_ULT:  res = MAX_WIDTH'(a < b);
         FN_ULE:  res = MAX_WIDTH'(a <= b);
         FN_SGT:  res = MAX_WIDTH'((a ^ sbit) > (b ^ sbit));
         FN_SGE:  res = MAX_WIDTH'((a ^ sbit) >= (b ^ sbit));
         FN_SLT:  res = MAX_WIDTH'((a ^ sbit) < (b ^ sbit));
         FN_SLE:  res = MAX_WIDTH'((a ^ sbit) <= (b ^ sbit));
         default: entry.status = ST_UNSUP;
      endcase

      if (!w_ok) begin
         entry.kind   = KIND_SIMPLE;
         entry.status = ST_UNSUP;
         entry.neg    = 1'b0;
         res          = '0;
      end

      if (entry.kind == KIND_SIMPLE) begin
         res = res & mask;
      end
      entry.acc[MAX_WIDTH-1:0] = res;
   end

endmodule

@@ hw/rtl/mia_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mia_queue
// Short queue of decoded beats between front and back end.
// ----------------------------------------------------------------------------
module mia_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mia_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output mia_pkg::entry_type head
);
   import mia_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   entry_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]     cnt_ff, cnt_in;
   logic            do_pop;

   always_comb begin
      full      = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
      not_empty = (cnt_ff != '0);
      head      = mem_ff[rd_ff];
      do_pop    = pop && not_empty;
      wr_in     = push ? wr_ff + 1'b1 : wr_ff;
      rd_in     = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in    = cnt_ff + (PW+1)'(push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/mia_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mia_back
// Execution pipeline: one restoring divide step per stage, a split multiply
// in the first two stages, then sign fix, width cut and result register.
// ----------------------------------------------------------------------------
module mia_back #(
   parameter int MAX_WIDTH = mia_pkg::MAX_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  mia_pkg::entry_type in_entry,
   output logic               rsp_valid,
   output mia_pkg::rsp_type   rsp_payload
);
   import mia_pkg::*;

   localparam int HALF = MAX_WIDTH / 2;
   localparam int HI   = MAX_WIDTH - HALF;

   entry_type stg_ff [MAX_WIDTH];
   entry_type stg_in [MAX_WIDTH];
   logic      vld_ff [MAX_WIDTH];
   logic      rsp_valid_ff;
   rsp_type   rsp_ff, rsp_in;

   for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_stage
      entry_type              e;
      logic                   v;
      logic [MAX_WIDTH:0]     trial, diff;
      logic                   ge;
      logic [2*HALF-1:0]      p_lo;
      logic [HALF+HI-1:0]     p_x, p_y;
      logic [HI-1:0]          mid;

      if (i == 0) begin : g_first
         assign e = in_entry;
         assign v = in_valid;
      end else begin : g_next
         assign e = stg_ff[i-1];
         assign v = vld_ff[i-1];
      end

      always_comb begin
         trial = {e.rem[MAX_WIDTH-1:0], e.acc[MAX_WIDTH-1]};
         diff  = trial - {1'b0, e.dvs[MAX_WIDTH-1:0]};
         ge    = (trial >= {1'b0, e.dvs[MAX_WIDTH-1:0]});
         p_lo  = e.acc[HALF-1:0] * e.dvs[HALF-1:0];
         p_x   = e.acc[HALF-1:0] * e.dvs[MAX_WIDTH-1:HALF];
         p_y   = e.acc[MAX_WIDTH-1:HALF] * e.dvs[HALF-1:0];
         mid   = p_x[HI-1:0] + p_y[HI-1:0];
         stg_in[i] = e;
         case (e.kind)
            KIND_DIV: begin
               stg_in[i].rem[MAX_WIDTH-1:0] = ge ? diff[MAX_WIDTH-1:0]
                                                 : trial[MAX_WIDTH-1:0];
               stg_in[i].acc[MAX_WIDTH-1:0] = {e.acc[MAX_WIDTH-2:0], ge};
            end
            KIND_MUL: begin
               if (i == 0) begin
                  stg_in[i].acc[MAX_WIDTH-1:0] = MAX_WIDTH'(p_lo);
                  stg_in[i].dvs[MAX_WIDTH-1:0] = {mid, {HALF{1'b0}}};
               end else if (i == 1) begin
                  stg_in[i].acc[MAX_WIDTH-1:0] = e.acc[MAX_WIDTH-1:0]
                                               + e.dvs[MAX_WIDTH-1:0];
               end
            end
            default: begin
            end
         endcase
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= v;
         end
      end

      always_ff @(posedge clock) begin
         stg_ff[i] <= stg_in[i];
      end
   end

   entry_type            last;
   logic [DATA_W-1:0]    lmask_full;
   logic [MAX_WIDTH-1:0] lmask, q;

   always_comb begin
      last       = stg_ff[MAX_WIDTH-1];
      lmask_full = width_mask(last.wcode);
      lmask      = lmask_full[MAX_WIDTH-1:0];
      q          = last.acc[MAX_WIDTH-1:0];
      rsp_in.status = last.status;
      case (last.kind)
         KIND_SEXT: rsp_in.result_value = DATA_W'($signed(q));
         KIND_MUL:  rsp_in.result_value = DATA_W'(q & lmask);
         KIND_DIV:  rsp_in.result_value = DATA_W'((last.neg ? -q : q) & lmask);
         default:   rsp_in.result_value = DATA_W'(q);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[MAX_WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ hw/rtl/multiwidth_integer_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiwidth_integer_alu
// Every operation passes through the queue, the divide pipeline (one quotient
// bit per stage) and the result register on its way to rsp_valid.
// Throughput: one beat per cycle; busy only rises if the queue fills.
// Reset clears the queue, stage valids and the result strobe.
// ----------------------------------------------------------------------------
module multiwidth_integer_alu #(
   parameter int MAX_WIDTH = mia_pkg::MAX_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mia_pkg::req_type req_payload,
   output logic             rsp_valid,
   output mia_pkg::rsp_type rsp_payload
);
   import mia_pkg::*;

   entry_type front_entry, head;
   logic      q_full, q_nonempty, push;

   assign busy = q_full;
   assign push = start && !q_full;

   mia_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .req_payload (req_payload),
      .entry       (front_entry)
   );

   mia_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (1'b1),
      .full       (q_full),
      .not_empty  (q_nonempty),
      .head       (head)
   );

   mia_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_nonempty),
      .in_entry    (head),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ hw/rtl/mia_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mia_checker
// Port-level checks on the ALU: busy never raised, fixed latency, status and result coding.
// ----------------------------------------------------------------------------
module mia_checker #(
   parameter int MAX_WIDTH = mia_pkg::MAX_WIDTH_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input mia_pkg::rsp_type rsp_payload,
   input logic             rsp_valid
);
   import mia_pkg::*;

   localparam int LAT = MAX_WIDTH + 2;

   logic acc_beat;
   assign acc_beat = start && !busy;

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy) else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      acc_beat |-> ##LAT rsp_valid) else $error("result late or lost");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == ST_OK || rsp_payload.status == ST_DIV0
                     || rsp_payload.status == ST_UNSUP))
      else $error("bad status");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.result_value == '0)
      else $error("error result not zero");

endmodule

bind multiwidth_integer_alu mia_checker #(.MAX_WIDTH(MAX_WIDTH)) u_mia_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_payload (rsp_payload),
   .rsp_valid   (rsp_valid)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for multiwidth_integer_alu: directed corner operations
// per width, one operation per function code, then random bursts of operations,
// each result compared against an in-bench prediction of every function code.
// ----------------------------------------------------------------------------
module tb;
   import mia_pkg::*;

   localparam int LATENCY    = MAX_WIDTH_DEF + 2;
   localparam int STALL_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_valid;
   rsp_type rsp_payload;

   rsp_type alu_expected[$];
   int      fail_count = 0;
   int      beats_sent = 0;
   int      beats_checked = 0;
   int      idle_cycles;
   bit      tail_done = 1'b0;

   multiwidth_integer_alu i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type alu_predict(req_type rq);
      rsp_type     rs;
      int unsigned w;
      logic [63:0] mask, sbit, a, b, r, ua, ub, q;
      logic        an, bn;
      w    = 8 << rq.width_code;
      mask = width_mask(rq.width_code);
      sbit = 64'd1 << (w - 1);
      a    = rq.left_operand & mask;
      b    = rq.right_operand & mask;
      an   = (a & sbit) != 0;
      bn   = (b & sbit) != 0;
      r    = '0;
      rs.status = ST_OK;
      case (rq.func)
         FN_ADD:  r = a + b;
         FN_SUB:  r = a - b;
         FN_MUL:  r = a * b;
         FN_UDIV: begin
            if (b == 0) rs.status = ST_DIV0;
            else r = a / b;
         end
         FN_SDIV: begin
            if (b == 0) begin
               rs.status = ST_DIV0;
            end else begin
               ua = an ? ((64'd0 - a) & mask) : a;
               ub = bn ? ((64'd0 - b) & mask) : b;
               q  = ua / ub;
               r  = (an != bn) ? (64'd0 - q) : q;
            end
         end
         FN_AND:  r = a & b;
         FN_OR:   r = a | b;
         FN_XOR:  r = a ^ b;
         FN_SHL:  r = (b >= w) ? 64'd0 : (a << b[6:0]);
         FN_SHR:  r = (b >= w) ? 64'd0 : (a >> b[6:0]);
         FN_SAR: begin
            if (b >= w) r = an ? mask : 64'd0;
            else r = (a >> b[6:0]) | (an ? (mask & ~(mask >> b[6:0])) : 64'd0);
         end
         FN_SEXT: r = an ? (a | ~mask) : a;
         FN_EQ:   r = 64'(a == b);
         FN_NE:   r = 64'(a != b);
         FN_UGT:  r = 64'(a > b);
         FN_UGE:  r = 64'(a >= b);
         FN_ULT:  r = 64'(a < b);
         FN_ULE:  r = 64'(a <= b);
         FN_SGT:  r = 64'((a ^ sbit) > (b ^ sbit));
         FN_SGE:  r = 64'((a ^ sbit) >= (b ^ sbit));
         FN_SLT:  r = 64'((a ^ sbit) < (b ^ sbit));
         FN_SLE:  r = 64'((a ^ sbit) <= (b ^ sbit));
         default: rs.status = ST_UNSUP;
      endcase
      rs.result_value = (rq.func == FN_SEXT) ? r : (r & mask);
      return rs;
   endfunction

   // hold start until the beat is taken
   task automatic send_op(logic [4:0] fn, logic [1:0] wc, logic [63:0] a, logic [63:0] b);
      req_type rq;
      rq.func          = fn;
      rq.width_code    = wc;
      rq.left_operand  = a;
      rq.right_operand = b;
      start       <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      alu_expected.insert(alu_expected.size(), alu_predict(rq));
      beats_sent++;
   endtask

   task automatic pause(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (alu_expected.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // operands biased towards edges of the selected width
   function automatic logic [63:0] pick_operand(logic [1:0] wc);
      int unsigned w;
      logic [63:0] m;
      w = 8 << wc;
      m = width_mask(wc);
      case ($urandom_range(0, 7))
         0: return 64'd0;
         1: return m;
         2: return 64'd1 << (w - 1);
         3: return (64'd1 << (w - 1)) - 1;
         4: return 64'($urandom_range(0, 70));
         5: return rand64() | ~m;
         default: return rand64();
      endcase
   endfunction

   task automatic test_directed();
      logic [63:0] m, smin;
      for (int wc = 0; wc < 4; wc++) begin
         m    = width_mask(2'(wc));
         smin = 64'd1 << ((8 << wc) - 1);
         send_op(FN_ADD,  2'(wc), m, 64'd1);
         send_op(FN_SUB,  2'(wc), 64'd0, 64'd1);
         send_op(FN_MUL,  2'(wc), m, m);
         send_op(FN_UDIV, 2'(wc), m, 64'd0);
         send_op(FN_SDIV, 2'(wc), smin, m);
         send_op(FN_SAR,  2'(wc), smin, 64'((8 << wc) - 1));
      end
      send_op(FN_SHL,  2'd3, '1, 64'd64);
      send_op(FN_SHR,  2'd0, 64'hff, 64'hff08);
      send_op(FN_SAR,  2'd1, 64'h8000, 64'd16);
      send_op(FN_SEXT, 2'd2, 64'hffff_ffff_8000_0000, '1);
      send_op(FN_SLT,  2'd0, 64'h80, 64'h7f);
      send_op(FN_SDIV, 2'd1, 64'hfff9, 64'd2);
      send_op(5'd22,   2'd0, '1, '1);
      send_op(5'd31,   2'd3, '1, '1);
      drain();
   endtask

   task automatic test_all_codes();
      for (int fn = 0; fn < 32; fn++)
         send_op(5'(fn), 2'($urandom_range(0, 3)), rand64(), rand64());
      drain();
   endtask

   task automatic test_random(int count);
      int n;
      logic [1:0] wc;
      logic [4:0] fn;
      n = 0;
      while (n < count) begin
         for (int k = $urandom_range(1, 24); k > 0 && n < count; k--) begin
            wc = 2'($urandom_range(0, 3));
            fn = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(22, 31))
                                             : 5'($urandom_range(0, 21));
            send_op(fn, wc, pick_operand(wc), pick_operand(wc));
            n++;
         end
         if ($urandom_range(0, 3) != 0)
            pause($urandom_range(1, 12));
      end
      drain();
   endtask

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (alu_expected.size() == 0) begin
            $error("unexpected result beat: result_value %h status %0d",
                   rsp_payload.result_value, rsp_payload.status);
            fail_count++;
         end else begin
            exp_rsp = alu_expected.pop_front();
            beats_checked++;
            if (rsp_payload.result_value !== exp_rsp.result_value) begin
               $error("result_value: expected %h actual %h",
                      exp_rsp.result_value, rsp_payload.result_value);
               fail_count++;
            end
            if (rsp_payload.status !== exp_rsp.status) begin
               $error("status: expected %0d actual %0d",
                      exp_rsp.status, rsp_payload.status);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || tail_done || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("multiwidth_integer_alu: mismatch");
            $finish;
         end
      end
   end

   initial begin
      start         = 1'b0;
      req_payload   = '0;
      reset         = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_all_codes();
      test_random(540);
      repeat (LATENCY + 10) @(posedge clock);
      tail_done = 1'b1;
      if (alu_expected.size() != 0)
         $error("%0d result beats never arrived", alu_expected.size());
      $display("covered %0d operation beats over all codes and widths, %0d results checked",
               beats_sent, beats_checked);
      if (fail_count == 0 && alu_expected.size() == 0)
         $display("multiwidth_integer_alu: match");
      else
         $display("multiwidth_integer_alu: mismatch");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/mia_pkg.sv
hw/rtl/mia_front.sv
hw/rtl/mia_queue.sv
hw/rtl/mia_back.sv
hw/rtl/multiwidth_integer_alu.sv
hw/rtl/mia_checker.sv
tb/tb.sv
